// ===== sv/sot_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sot_pkg;

   typedef enum logic [2:0] {
      KIND_WORD_CHAR   = 3'd0,
      KIND_WORD_END    = 3'd1,
      KIND_OPERATOR    = 3'd2,
      KIND_LINE_END    = 3'd3,
      KIND_QUOTE_ERROR = 3'd4
   } kind_type;

   localparam logic [3:0] OP_PIPE     = 4'd0;
   localparam logic [3:0] OP_OR       = 4'd1;
   localparam logic [3:0] OP_AMP      = 4'd2;
   localparam logic [3:0] OP_AND      = 4'd3;
   localparam logic [3:0] OP_GT       = 4'd4;
   localparam logic [3:0] OP_APPEND   = 4'd5;
   localparam logic [3:0] OP_LT       = 4'd6;
   localparam logic [3:0] OP_HEREDOC  = 4'd7;
   localparam logic [3:0] OP_SEMI     = 4'd8;
   localparam logic [3:0] OP_LPAREN   = 4'd9;
   localparam logic [3:0] OP_RPAREN   = 4'd10;
   localparam logic [3:0] OP_LBRACKET = 4'd11;
   localparam logic [3:0] OP_RBRACKET = 4'd12;
   localparam logic [3:0] OP_NONE     = 4'd0;

   localparam logic [7:0] CHAR_QUOTE    = 8'h22;
   localparam logic [7:0] CHAR_AMP      = 8'h26;
   localparam logic [7:0] CHAR_LPAREN   = 8'h28;
   localparam logic [7:0] CHAR_RPAREN   = 8'h29;
   localparam logic [7:0] CHAR_SEMI     = 8'h3B;
   localparam logic [7:0] CHAR_LT       = 8'h3C;
   localparam logic [7:0] CHAR_GT       = 8'h3E;
   localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET = 8'h5D;
   localparam logic [7:0] CHAR_PIPE     = 8'h7C;

   localparam logic [1:0] DCLASS_PIPE = 2'd0;
   localparam logic [1:0] DCLASS_AMP  = 2'd1;
   localparam logic [1:0] DCLASS_GT   = 2'd2;
   localparam logic [1:0] DCLASS_LT   = 2'd3;

   // result slots of one transaction, in emission order
   localparam int SLOT_PENDING   = 0;
   localparam int SLOT_CLOSE     = 1;
   localparam int SLOT_MAIN      = 2;
   localparam int SLOT_FLUSH     = 3;
   localparam int SLOT_END_CLOSE = 4;
   localparam int SLOT_TERM      = 5;
   localparam int NUM_SLOTS      = 6;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [NUM_SLOTS-1:0] mask;
      logic [3:0]           first_op;
      kind_type             main_kind;
      logic [7:0]           main_char;
      logic [3:0]           main_op;
      logic [3:0]           flush_op;
      logic                 quote_error;
   } plan_type;

   typedef struct packed {
      logic       hit;
      logic [1:0] idx;
   } dclass_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] code;
   } sclass_type;

   function automatic dclass_type double_class(input logic [7:0] c);
      dclass_type r;
      r.hit = 1'b1;
      unique case (c)
         CHAR_PIPE: r.idx = DCLASS_PIPE;
         CHAR_AMP:  r.idx = DCLASS_AMP;
         CHAR_GT:   r.idx = DCLASS_GT;
         CHAR_LT:   r.idx = DCLASS_LT;
         default: begin
            r.hit = 1'b0;
            r.idx = DCLASS_PIPE;
         end
      endcase
      return r;
   endfunction

   function automatic sclass_type single_class(input logic [7:0] c);
      sclass_type r;
      r.hit = 1'b1;
      unique case (c)
         CHAR_SEMI:     r.code = OP_SEMI;
         CHAR_LPAREN:   r.code = OP_LPAREN;
         CHAR_RPAREN:   r.code = OP_RPAREN;
         CHAR_LBRACKET: r.code = OP_LBRACKET;
         CHAR_RBRACKET: r.code = OP_RBRACKET;
         default: begin
            r.hit  = 1'b0;
            r.code = OP_NONE;
         end
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/sot_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sot_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       line_last;

   modport source (output valid, output char_in, output line_last, input ready);
   modport sink (input valid, input char_in, input line_last, output ready);
endinterface

interface sot_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] char_out;
   logic [3:0] operator_code;
   logic       result_last;

   modport source (output valid, output kind, output char_out, output operator_code,
                   output result_last, input ready);
   modport sink (input valid, input kind, input char_out, input operator_code,
                 input result_last, output ready);
endinterface

`default_nettype wire

// ===== sv/sot_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sot_front
   import sot_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire logic [7:0] char_in,
   input  wire logic       line_last,
   input  wire logic       queue_full,
   output logic            push,
   output plan_type        plan
);

   logic       in_quote_ff, in_quote_in;
   logic       word_open_ff, word_open_in;
   logic       pending_valid_ff, pending_valid_in;
   logic [1:0] pending_first_ff, pending_first_in;

   dclass_type dc;
   sclass_type sc;
   logic       accept;
   logic       matched;
   logic       quote_n;
   logic       word_n;
   logic       pv_n;
   logic [1:0] pf_n;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;
   assign push     = accept && (plan.mask != '0);

   always_comb begin
      dc      = double_class(char_in);
      sc      = single_class(char_in);
      matched = pending_valid_ff && !in_quote_ff && dc.hit && (dc.idx == pending_first_ff);
      quote_n = in_quote_ff;
      word_n  = word_open_ff;
      pv_n    = 1'b0;
      pf_n    = 2'd0;

      plan             = '0;
      plan.first_op    = {1'b0, pending_first_ff, matched};
      plan.main_kind   = KIND_WORD_CHAR;
      plan.main_char   = char_in;
      plan.main_op     = OP_NONE;
      plan.mask[SLOT_PENDING] = pending_valid_ff;

      if (!matched) begin
         priority if (char_in == CHAR_QUOTE) begin
            quote_n = !in_quote_ff;
            word_n  = 1'b1;
            plan.mask[SLOT_MAIN] = 1'b1;
         end else if (!in_quote_ff && dc.hit) begin
            plan.mask[SLOT_CLOSE] = word_open_ff;
            word_n = 1'b0;
            pv_n   = 1'b1;
            pf_n   = dc.idx;
         end else if (!in_quote_ff && sc.hit) begin
            plan.mask[SLOT_CLOSE] = word_open_ff;
            word_n         = 1'b0;
            plan.main_kind = KIND_OPERATOR;
            plan.main_char = 8'd0;
            plan.main_op   = sc.code;
            plan.mask[SLOT_MAIN] = 1'b1;
         end else begin
            word_n = 1'b1;
            plan.mask[SLOT_MAIN] = 1'b1;
         end
      end

      plan.flush_op    = {1'b0, pf_n, 1'b0};
      plan.quote_error = quote_n;
      if (line_last) begin
         plan.mask[SLOT_FLUSH]     = pv_n;
         plan.mask[SLOT_END_CLOSE] = word_n;
         plan.mask[SLOT_TERM]      = 1'b1;
      end

      in_quote_in      = in_quote_ff;
      word_open_in     = word_open_ff;
      pending_valid_in = pending_valid_ff;
      pending_first_in = pending_first_ff;
      if (accept) begin
         in_quote_in      = quote_n && !line_last;
         word_open_in     = word_n && !line_last;
         pending_valid_in = pv_n && !line_last;
         pending_first_in = line_last ? 2'd0 : pf_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_quote_ff      <= 1'b0;
         word_open_ff     <= 1'b0;
         pending_valid_ff <= 1'b0;
         pending_first_ff <= 2'd0;
      end else begin
         in_quote_ff      <= in_quote_in;
         word_open_ff     <= word_open_in;
         pending_valid_ff <= pending_valid_in;
         pending_first_ff <= pending_first_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/sot_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sot_queue
   import sot_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire plan_type push_plan,
   input  wire logic     pop,
   output logic          full,
   output logic          not_empty,
   output plan_type      head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

   plan_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == DEPTH_CNT);
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_plan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/sot_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sot_back
   import sot_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       queue_not_empty,
   input  wire plan_type   queue_head,
   output logic            pop,
   output logic            out_valid,
   input  wire logic       out_ready,
   output logic [2:0]      kind,
   output logic [7:0]      char_out,
   output logic [3:0]      operator_code,
   output logic            result_last
);

   logic [NUM_SLOTS-1:0] mask_ff, mask_in;
   plan_type             plan_ff, plan_in;
   logic [NUM_SLOTS-1:0] low;
   logic [NUM_SLOTS-1:0] rest;
   logic                 take;
   kind_type             kind_sel;

   // lowest pending slot is the one on show
   assign low         = mask_ff & (~mask_ff + 1'b1);
   assign rest        = mask_ff & ~low;
   assign out_valid   = (mask_ff != '0);
   assign take        = out_valid && out_ready;
   assign result_last = (rest == '0);
   assign pop         = queue_not_empty && (!out_valid || (take && rest == '0));
   assign kind        = kind_sel;

   always_comb begin
      kind_sel      = KIND_WORD_END;
      char_out      = 8'd0;
      operator_code = OP_NONE;
      priority if (low[SLOT_PENDING]) begin
         kind_sel      = KIND_OPERATOR;
         operator_code = plan_ff.first_op;
      end else if (low[SLOT_CLOSE]) begin
         kind_sel = KIND_WORD_END;
      end else if (low[SLOT_MAIN]) begin
         kind_sel      = plan_ff.main_kind;
         char_out      = plan_ff.main_char;
         operator_code = plan_ff.main_op;
      end else if (low[SLOT_FLUSH]) begin
         kind_sel      = KIND_OPERATOR;
         operator_code = plan_ff.flush_op;
      end else if (low[SLOT_END_CLOSE]) begin
         kind_sel = KIND_WORD_END;
      end else begin
         kind_sel = plan_ff.quote_error ? KIND_QUOTE_ERROR : KIND_LINE_END;
      end
   end

   always_comb begin
      mask_in = mask_ff;
      plan_in = plan_ff;
      if (pop) begin
         mask_in = queue_head.mask;
         plan_in = queue_head;
      end else if (take) begin
         mask_in = rest;
      end
   end

   always_ff @(posedge clock) begin
      plan_ff <= plan_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/shell_operator_tokenizer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake          payload
// req      in         valid/ready        char_in[7:0], line_last
// rsp      out        valid/ready        kind[2:0], char_out[7:0], operator_code[3:0],
//                                        result_last
//
// a byte is taken in every cycle while the two-entry plan queue has room
// each byte yields 0 to 4 results; the back end sends one result per cycle while rsp is ready
// first result of a byte passes through the plan queue and the back end's plan register
// reset is synchronous and clears tokenizer state, queue and output
// a stalled rsp fills the queue, then req ready drops

module shell_operator_tokenizer
   import sot_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   sot_req_if.sink   req,
   sot_rsp_if.source rsp
);

   logic     queue_full;
   logic     queue_not_empty;
   logic     push;
   logic     pop;
   plan_type front_plan;
   plan_type queue_head;

   sot_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req.valid),
      .in_ready   (req.ready),
      .char_in    (req.char_in),
      .line_last  (req.line_last),
      .queue_full (queue_full),
      .push       (push),
      .plan       (front_plan)
   );

   sot_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_plan (front_plan),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head      (queue_head)
   );

   sot_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .queue_head      (queue_head),
      .pop             (pop),
      .out_valid       (rsp.valid),
      .out_ready       (rsp.ready),
      .kind            (rsp.kind),
      .char_out        (rsp.char_out),
      .operator_code   (rsp.operator_code),
      .result_last     (rsp.result_last)
   );

endmodule

`default_nettype wire

// ===== sv/sot_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sot_checker
   import sot_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_kind,
   input wire logic [7:0] rsp_char_out,
   input wire logic [3:0] rsp_operator_code,
   input wire logic       rsp_result_last
);

   // stalled transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_char_out)
         && $stable(rsp_operator_code) && $stable(rsp_result_last))
      else $error("rsp payload changed while stalled");

   // a line terminator always closes the results of its byte
   a_term_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_LINE_END || rsp_kind == KIND_QUOTE_ERROR)
         |-> rsp_result_last)
      else $error("line end not marked last");

   // only word characters carry a byte, only operators carry a code
   a_payload_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_WORD_CHAR |-> rsp_char_out == 8'd0
         && (rsp_kind == KIND_OPERATOR || rsp_operator_code == OP_NONE))
      else $error("unused payload bits set");

   // kind and operator codes stay in range
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind <= KIND_QUOTE_ERROR && rsp_operator_code <= OP_RBRACKET)
      else $error("kind or operator code out of range");

   // nothing is offered straight after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind shell_operator_tokenizer sot_checker u_sot_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_kind          (rsp.kind),
   .rsp_char_out      (rsp.char_out),
   .rsp_operator_code (rsp.operator_code),
   .rsp_result_last   (rsp.result_last)
);

`default_nettype wire

// ===== verif/sot_token_checker.sv =====
`timescale 1ns / 1ps

module sot_token_checker
   import sot_pkg::*;
(
   input  logic clock,
   input  logic reset,
   sot_req_if   req,
   sot_rsp_if   rsp,
   output int   mismatch_count,
   output int   tokens_due
);

   typedef struct {
      kind_type   kind;
      logic [7:0] ch;
      logic [3:0] op;
      logic       last;
   } token_type;

   token_type  expected_tokens[$];
   token_type  staged[4];
   token_type  head_token;
   int         staged_n;
   logic       in_quote;
   logic       word_open;
   logic       op_held;
   logic [1:0] held_class;

   function automatic int pair_class(input logic [7:0] c);
      case (c)
         CHAR_PIPE: return DCLASS_PIPE;
         CHAR_AMP:  return DCLASS_AMP;
         CHAR_GT:   return DCLASS_GT;
         CHAR_LT:   return DCLASS_LT;
         default:   return -1;
      endcase
   endfunction

   function automatic int lone_operator(input logic [7:0] c);
      case (c)
         CHAR_SEMI:     return OP_SEMI;
         CHAR_LPAREN:   return OP_LPAREN;
         CHAR_RPAREN:   return OP_RPAREN;
         CHAR_LBRACKET: return OP_LBRACKET;
         CHAR_RBRACKET: return OP_RBRACKET;
         default:       return -1;
      endcase
   endfunction

   task automatic stage(input kind_type k, input logic [7:0] c, input logic [3:0] o);
      staged[staged_n] = '{kind: k, ch: c, op: o, last: 1'b0};
      staged_n++;
   endtask

   task automatic close_word();
      if (word_open) begin
         stage(KIND_WORD_END, 8'h00, OP_NONE);
         word_open = 1'b0;
      end
   endtask

   task automatic clear_lexer();
      in_quote   = 1'b0;
      word_open  = 1'b0;
      op_held    = 1'b0;
      held_class = DCLASS_PIPE;
   endtask

   task automatic predict_tokens(input logic [7:0] c, input logic eol);
      int   pc;
      int   sc;
      logic taken;
      pc       = pair_class(c);
      sc       = lone_operator(c);
      taken    = 1'b0;
      staged_n = 0;
      // held operator byte meets its lookahead
      if (op_held) begin
         if (!in_quote && pc >= 0 && pc == int'(held_class)) begin
            stage(KIND_OPERATOR, 8'h00, {1'b0, held_class, 1'b1});
            taken = 1'b1;
         end else begin
            stage(KIND_OPERATOR, 8'h00, {1'b0, held_class, 1'b0});
         end
         op_held    = 1'b0;
         held_class = DCLASS_PIPE;
      end
      if (!taken) begin
         if (c == CHAR_QUOTE) begin
            in_quote = !in_quote;
            stage(KIND_WORD_CHAR, c, OP_NONE);
            word_open = 1'b1;
         end else if (!in_quote && pc >= 0) begin
            close_word();
            op_held    = 1'b1;
            held_class = pc[1:0];
         end else if (!in_quote && sc >= 0) begin
            close_word();
            stage(KIND_OPERATOR, 8'h00, sc[3:0]);
         end else begin
            stage(KIND_WORD_CHAR, c, OP_NONE);
            word_open = 1'b1;
         end
      end
      if (eol) begin
         if (op_held)
            stage(KIND_OPERATOR, 8'h00, {1'b0, held_class, 1'b0});
         close_word();
         stage(in_quote ? KIND_QUOTE_ERROR : KIND_LINE_END, 8'h00, OP_NONE);
         clear_lexer();
      end
      if (staged_n > 0)
         staged[staged_n-1].last = 1'b1;
      for (int i = 0; i < staged_n; i++)
         expected_tokens.push_back(staged[i]);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_tokens.delete();
         clear_lexer();
         mismatch_count = 0;
      end else begin
         if (req.valid && req.ready)
            predict_tokens(req.char_in, req.line_last);
         if (rsp.valid && rsp.ready) begin
            if (expected_tokens.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: unexpected result kind %0d char %02h op %0d last %b",
                           $realtime, rsp.kind, rsp.char_out, rsp.operator_code,
                           rsp.result_last);
               mismatch_count++;
            end else begin
               head_token = expected_tokens.pop_front();
               if (rsp.kind !== head_token.kind || rsp.char_out !== head_token.ch ||
                   rsp.operator_code !== head_token.op ||
                   rsp.result_last !== head_token.last) begin
                  if (mismatch_count < 10)
                     $display({"%0t: result mismatch, expected kind %0d char %02h op %0d",
                               " last %b, got kind %0d char %02h op %0d last %b"},
                              $realtime, head_token.kind, head_token.ch, head_token.op,
                              head_token.last, rsp.kind, rsp.char_out,
                              rsp.operator_code, rsp.result_last);
                  mismatch_count++;
               end
            end
         end
      end
      tokens_due <= expected_tokens.size();
   end

endmodule

// ===== verif/shell_operator_tokenizer_test.sv =====
`timescale 1ns / 1ps

module shell_operator_tokenizer_test;
   import sot_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_BYTES = 120;
   localparam int HOLD_CYCLES = 80;

   logic clock;
   logic reset;
   int   send_idle_pct = 21;
   int   take_idle_pct = 67;
   logic hold_request  = 1'b0;
   int   hold_left     = 0;
   int   mismatch_count;
   int   tokens_due;
   int   bytes_sent    = 0;

   sot_req_if req_ch();
   sot_rsp_if rsp_ch();

   shell_operator_tokenizer DUT (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   sot_token_checker token_check (
      .clock         (clock),
      .reset         (reset),
      .req           (req_ch),
      .rsp           (rsp_ch),
      .mismatch_count(mismatch_count),
      .tokens_due    (tokens_due)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // receiver, with one long hold-off in the last phase
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= take_idle_pct);
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("shell_operator_tokenizer verification failed");
      $finish;
   end

   task automatic send_byte(input logic [7:0] c, input logic eol);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.char_in   <= c;
      req_ch.line_last <= eol;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], i == s.len() - 1);
   endtask

   function automatic logic [7:0] operator_char(input int k);
      case (k)
         0:       return CHAR_PIPE;
         1:       return CHAR_AMP;
         2:       return CHAR_GT;
         3:       return CHAR_LT;
         4:       return CHAR_SEMI;
         5:       return CHAR_LPAREN;
         6:       return CHAR_RPAREN;
         7:       return CHAR_LBRACKET;
         default: return CHAR_RBRACKET;
      endcase
   endfunction

   task automatic send_random_line();
      int         len;
      int         r;
      logic [7:0] c;
      logic [7:0] prev;
      len  = $urandom_range(12, 1);
      prev = 8'h61;
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(99);
         if (r < 15)
            c = prev;
         else if (r < 45)
            c = operator_char($urandom_range(8));
         else if (r < 55)
            c = CHAR_QUOTE;
         else if (r < 85)
            c = 8'($urandom_range(8'h7e, 8'h20));
         else
            c = 8'($urandom());
         send_byte(c, i == len - 1);
         prev = c;
      end
   endtask

   // sender pauses until every expected result has come back
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (tokens_due != 0) @(posedge clock);
   endtask

   initial begin
      int target;
      bit hold_issued;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.char_in   = 8'h00;
      req_ch.line_last = 1'b0;
      hold_issued      = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // doubled operators, singles, lookahead mismatches, held operator at line end
      send_text("x||&&>><<;()[]");
      send_text("|&><");
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      // unclosed quote
      send_text("\"a;b");
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 21;
               take_idle_pct = 67;
            end
            1: begin
               send_idle_pct = 67;
               take_idle_pct = 21;
            end
            default: begin
               send_idle_pct = 0;
               take_idle_pct = 0;
            end
         endcase
         target = bytes_sent + PHASE_BYTES;
         while (bytes_sent < target) begin
            if (phase == 2 && bytes_sent >= target - PHASE_BYTES / 2 && hold_left == 0 &&
                !hold_request && !hold_issued) begin
               hold_request = 1'b1;
               hold_issued  = 1'b1;
            end
            send_random_line();
         end
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && tokens_due == 0)
         $display("shell_operator_tokenizer verification clean");
      else
         $display("shell_operator_tokenizer verification failed");
      $finish;
   end

endmodule
